### hw/rtl/dcr_pkg.sv
// Shared types, constants and arithmetic helpers for the ADC DC-removal PCM packer.
// Used by dcr_in_reg, dcr_core and adc_dc_removal_pcm_packer.
`timescale 1ns / 1ps

package dcr_pkg;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STOP   = 1'b1;

  // Calibration length (a power of two, so the mean is a shift)
  localparam int CAL_SAMPLES = 512;
  localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int CAL_SUM_W   = 12 + $clog2(CAL_SAMPLES);

  // Chunk length in 16-bit samples, odd byte counts round up
  localparam int CHUNK_BYTES       = 1024;
  localparam int SAMPLES_PER_CHUNK = (CHUNK_BYTES + 1) / 2;
  localparam int FILL_W            = $clog2(SAMPLES_PER_CHUNK + 1);

  // Baseline tracking: b' = b + floor((raw - b) / 100)
  localparam logic [11:0] BASELINE_RESET = 12'd2048;
  localparam int          DIV_SHIFT      = 19;
  localparam logic [12:0] DIV_RECIP      = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [12:0] DIV_ROUND      = 13'd99;

  localparam logic signed [16:0] PCM_MAX = 17'sd32767;
  localparam logic signed [16:0] PCM_MIN = -17'sd32768;

  typedef struct packed {
    logic        kind;
    logic [11:0] raw_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               chunk_end;
    logic               flush_marker;
  } out_t;

  // Registered input stage handed to the core
  typedef struct packed {
    logic valid;
    in_t  item;
  } stage_t;

  // One step of the moving average: floor((b*99 + raw) / 100)
  function automatic logic [11:0] baseline_step(input logic [11:0] b, input logic [11:0] raw);
    logic signed [12:0] d;
    logic [12:0]        adj;
    logic [24:0]        prod;
    logic [5:0]         q;
    logic [11:0]        res;
    d = $signed({1'b0, raw}) - $signed({1'b0, b});
    // negative differences round toward minus infinity
    if (d < 0) begin
      adj = 13'(-d) + DIV_ROUND;
    end else begin
      adj = 13'(d);
    end
    prod = 25'(adj) * 25'(DIV_RECIP);
    q    = prod[24:DIV_SHIFT];
    if (d < 0) begin
      res = b - 12'(q);
    end else begin
      res = b + 12'(q);
    end
    return res;
  endfunction

  // Center, scale by 16 and saturate to signed 16 bits
  function automatic logic signed [15:0] scale_clamp(input logic [11:0] raw,
                                                     input logic [11:0] b);
    logic signed [12:0] centered;
    logic signed [16:0] scaled;
    logic signed [15:0] res;
    centered = $signed({1'b0, raw}) - $signed({1'b0, b});
    scaled   = 17'(centered) <<< 4;
    if (scaled > PCM_MAX) begin
      res = 16'sh7FFF;
    end else if (scaled < PCM_MIN) begin
      res = -16'sh8000;
    end else begin
      res = scaled[15:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/dcr_in_reg.sv
// Input register stage: captures one transaction and holds it until the core takes it.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcr_pkg::in_t  in_item,
  input  logic          advance,
  output dcr_pkg::stage_t stage
);

  logic          held;
  dcr_pkg::in_t  item;

  // stage empties when the core advances, so it can refill in the same cycle
  assign in_ready = advance || !held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign stage.valid = held;
  assign stage.item  = item;

endmodule

### hw/rtl/dcr_core.sv
// Calibration, baseline tracking, scaling and chunk counting, with the result register.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_core (
  input  logic            clk,
  input  logic            rst,
  input  dcr_pkg::stage_t stage,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_ready,
  output dcr_pkg::out_t   out_item
);

  logic [11:0]                   baseline;
  logic [dcr_pkg::CAL_SUM_W-1:0] cal_sum;
  logic [dcr_pkg::CAL_CNT_W-1:0] cal_count;
  logic                          calibrating;
  logic [dcr_pkg::FILL_W-1:0]    chunk_fill;

  logic [11:0]                   baseline_next;
  logic [dcr_pkg::CAL_SUM_W-1:0] cal_sum_next;
  logic [dcr_pkg::CAL_CNT_W-1:0] cal_count_next;
  logic                          calibrating_next;
  logic [dcr_pkg::FILL_W-1:0]    chunk_fill_next;
  logic                          produce;
  dcr_pkg::out_t                 res;

  logic [dcr_pkg::CAL_CNT_W-1:0] cal_count_inc;
  logic [dcr_pkg::FILL_W-1:0]    fill_inc;
  logic [11:0]                   tracked;

  // result register frees up when empty or being taken
  assign advance = !out_valid || out_ready;

  assign cal_count_inc = cal_count + 1'b1;
  assign fill_inc      = chunk_fill + 1'b1;
  assign tracked       = dcr_pkg::baseline_step(baseline, stage.item.raw_sample);

  // next state and result for the item in the input stage
  always_comb begin
    baseline_next    = baseline;
    cal_sum_next     = cal_sum;
    cal_count_next   = cal_count;
    calibrating_next = calibrating;
    chunk_fill_next  = chunk_fill;
    produce          = 1'b0;
    res.pcm_sample   = '0;
    res.chunk_end    = 1'b0;
    res.flush_marker = 1'b0;
    case (stage.item.kind)
      dcr_pkg::KIND_STOP: begin
        // flush a partial chunk, then recalibrate
        produce          = (chunk_fill != '0);
        res.chunk_end    = 1'b1;
        res.flush_marker = 1'b1;
        chunk_fill_next  = '0;
        cal_sum_next     = '0;
        cal_count_next   = '0;
        calibrating_next = 1'b1;
      end
      dcr_pkg::KIND_SAMPLE: begin
        if (calibrating) begin
          cal_sum_next   = cal_sum + dcr_pkg::CAL_SUM_W'(stage.item.raw_sample);
          cal_count_next = cal_count_inc;
          if (cal_count_inc >= dcr_pkg::CAL_CNT_W'(dcr_pkg::CAL_SAMPLES)) begin
            baseline_next    = 12'(cal_sum_next / dcr_pkg::CAL_SAMPLES);
            calibrating_next = 1'b0;
            cal_sum_next     = '0;
            cal_count_next   = '0;
          end
        end else begin
          baseline_next  = tracked;
          produce        = 1'b1;
          res.pcm_sample = dcr_pkg::scale_clamp(stage.item.raw_sample, tracked);
          if (fill_inc >= dcr_pkg::FILL_W'(dcr_pkg::SAMPLES_PER_CHUNK)) begin
            res.chunk_end   = 1'b1;
            chunk_fill_next = '0;
          end else begin
            chunk_fill_next = fill_inc;
          end
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline    <= dcr_pkg::BASELINE_RESET;
      cal_sum     <= '0;
      cal_count   <= '0;
      calibrating <= 1'b1;
      chunk_fill  <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid && produce;
      if (stage.valid) begin
        baseline    <= baseline_next;
        cal_sum     <= cal_sum_next;
        cal_count   <= cal_count_next;
        calibrating <= calibrating_next;
        chunk_fill  <= chunk_fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid && produce) begin
      out_item <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // a flush marker always closes a chunk and carries no sample
  a_flush_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.flush_marker |-> out_item.chunk_end && out_item.pcm_sample == '0)
    else $error("flush marker with bad fields");

  // the chunk counter never reaches the chunk length
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    chunk_fill < dcr_pkg::FILL_W'(dcr_pkg::SAMPLES_PER_CHUNK))
    else $error("chunk fill out of range");

  // outside calibration the accumulator is idle and cleared
  a_cal_idle: assert property (@(posedge clk) disable iff (rst)
    !calibrating |-> cal_count == '0 && cal_sum == '0)
    else $error("calibration accumulator busy outside calibration");

  // no sample result is produced while calibrating
  a_no_cal_output: assert property (@(posedge clk) disable iff (rst)
    advance && stage.valid && calibrating && stage.item.kind == dcr_pkg::KIND_SAMPLE
    |=> !out_valid)
    else $error("result produced during calibration");

  // a stop always restarts calibration
  a_stop_recal: assert property (@(posedge clk) disable iff (rst)
    advance && stage.valid && stage.item.kind == dcr_pkg::KIND_STOP
    |=> calibrating && chunk_fill == '0)
    else $error("stop did not restart calibration");
`endif

endmodule

### hw/rtl/adc_dc_removal_pcm_packer.sv
// ADC DC-removal PCM packer: usage notes
//   Input channel (in_valid / in_ready / in_item): one transaction per ADC sample
//   (kind = sample) or per stop request (kind = stop, raw_sample ignored).
//   Output channel (out_valid / out_ready / out_item): zero or one PCM result per
//   input transaction, in input order.
//   After reset, and after every stop, the first 512 samples only set the DC
//   baseline (their mean) and give no result. Later samples update the baseline
//   as a 1/100 moving average, are centered, scaled by 16, saturated to 16 bits
//   and emitted; the last sample of each 512-sample chunk has chunk_end set.
//   A stop with a partly filled chunk gives one marker result (pcm 0, chunk_end
//   and flush_marker set); with an empty chunk it gives nothing.
//   Each input transaction passes through the input register, then the result
//   register. Throughput: one transaction per cycle while the receiver does not
//   stall; the baseline update is a single constant-reciprocal multiply and add
//   per cycle.
//   When the receiver stalls, the result register holds and the input register
//   takes one more transaction only if it was empty; then in_ready drops.
//   Reset (rst, synchronous, active high) empties both stages, sets the baseline
//   to mid-scale and starts calibration.
// Depends on dcr_pkg, dcr_in_reg and dcr_core.
`timescale 1ns / 1ps

module adc_dc_removal_pcm_packer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcr_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output dcr_pkg::out_t out_item
);

  dcr_pkg::stage_t stage;
  logic            advance;

  // input register
  dcr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  // processing and result register
  dcr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
